>>> src/tws_pkg.sv
// ----------------------------------------------------------------------------
// Time window schedule package
// Shared constants and codes for the activity window schedule block.
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam int unsigned MAX_WINDOWS_DEF = 16;
  localparam int unsigned TIME_BITS_DEF   = 48;
  localparam int unsigned VER_W           = 32;
  localparam int unsigned LEAD_W          = 32;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_QUERY  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_INACTIVE    = 2'd0,
    ST_ESTABLISHED = 2'd1,
    ST_ACTIVE      = 2'd2
  } win_state_e;

endpackage

>>> src/tws_sub.sv
// ----------------------------------------------------------------------------
// Time window schedule subtractor
// Shared subtract and compare unit: difference and borrow of two times.
// ----------------------------------------------------------------------------
module tws_sub #(
  parameter int unsigned W = 48
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] diff_o,
  output logic         borrow_o
);

  assign {borrow_o, diff_o} = {1'b0, a_i} - {1'b0, b_i};

endmodule

>>> src/tws_store.sv
// ----------------------------------------------------------------------------
// Time window schedule store
// Window memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tws_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned EW    = 128
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [EW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [EW-1:0] rdata_o
);

  logic [EW-1:0] mem_q [DEPTH];
  logic [EW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/time_window_schedule_state.sv
// ----------------------------------------------------------------------------
// Time window schedule state
// Sorted table of activity windows with clear, insert and query commands.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Contents
//  command   start / busy          action, start, end, version, now time
//  result    done_o strobe         status, states, next time, range, count
//  config    lead_we_i             establish lead time
//
//  Clear, the unused code and a dropped insert strobe one cycle after they
//  are accepted. An insert moves each later-starting window up, then writes the
//  new one. A query passes over ended windows, then checks whether the first one
//  left is active and else works out its establish point, via the one read port
//  and the shared subtractor. Reset clears the sequencer, window count, lead and
//  done strobe; the memory holds no reset value. Each word is strobed for one cycle.
// ----------------------------------------------------------------------------
module time_window_schedule_state #(
  parameter int unsigned MAX_WINDOWS = tws_pkg::MAX_WINDOWS_DEF,
  parameter int unsigned TIME_BITS   = tws_pkg::TIME_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          action_i,
  input  logic [TIME_BITS-1:0]                start_time_i,
  input  logic [TIME_BITS-1:0]                end_time_i,
  input  logic [tws_pkg::VER_W-1:0]           version_i,
  input  logic [TIME_BITS-1:0]                now_time_i,
  input  logic                                lead_we_i,
  input  logic [tws_pkg::LEAD_W-1:0]          lead_wdata_i,
  output logic                                done_o,
  output logic                                status_o,
  output logic [1:0]                          current_state_o,
  output logic [TIME_BITS-1:0]                next_time_o,
  output logic [1:0]                          next_state_o,
  output logic                                next_valid_o,
  output logic [TIME_BITS-1:0]                range_start_o,
  output logic [TIME_BITS-1:0]                range_end_o,
  output logic                                range_valid_o,
  output logic [$clog2(MAX_WINDOWS+1)-1:0]    window_count_o
);
  import tws_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WINDOWS + 1);
  localparam int unsigned AW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int unsigned EW = 2 * TIME_BITS + VER_W;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_INS_CMP = 7'b0000010,
    S_INS_WR  = 7'b0000100,
    S_Q_CMP   = 7'b0001000,
    S_Q_ACT   = 7'b0010000,
    S_Q_LEAD  = 7'b0100000,
    S_Q_PRE   = 7'b1000000
  } fsm_e;

  fsm_e                 state_q, state_d;
  logic [LEAD_W-1:0]    lead_q;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        ptr_q, ptr_d;
  logic [CW-1:0]        cnt_m1, ptr_m1, ptr_m2, ptr_p1;
  logic [TIME_BITS-1:0] ts_q, te_q, now_q;
  logic [VER_W-1:0]     ver_q;
  logic [TIME_BITS-1:0] win_s_q, win_e_q, pre_q;
  logic [TIME_BITS-1:0] rs_q, rs_d, re_q, re_d;
  logic                 win_load, pre_load, fin;

  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [EW-1:0]        wdata, rdata;
  logic [TIME_BITS-1:0] rd_start, rd_end;

  logic [TIME_BITS-1:0] sub_a, sub_b, sub_diff;
  logic                 sub_borrow;

  logic                 done_q;
  logic                 status_q, status_d;
  win_state_e           cur_q, cur_d, ns_q, ns_d;
  logic [TIME_BITS-1:0] nt_q, nt_d;
  logic                 nv_q, nv_d;
  logic [TIME_BITS-1:0] ors_q, ors_d, ore_q, ore_d;
  logic                 orv_q, orv_d;
  logic [CW-1:0]        ocnt_q;

  tws_store #(
    .DEPTH (MAX_WINDOWS),
    .AW    (AW),
    .EW    (EW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  tws_sub #(
    .W (TIME_BITS)
  ) u_sub (
    .a_i      (sub_a),
    .b_i      (sub_b),
    .diff_o   (sub_diff),
    .borrow_o (sub_borrow)
  );

  assign rd_start = rdata[TIME_BITS-1:0];
  assign rd_end   = rdata[2*TIME_BITS-1:TIME_BITS];
  assign cnt_m1   = count_q - CW'(1);
  assign ptr_m1   = ptr_q - CW'(1);
  assign ptr_m2   = ptr_q - CW'(2);
  assign ptr_p1   = ptr_q + CW'(1);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ptr_d    = ptr_q;
    rs_d     = rs_q;
    re_d     = re_q;
    we       = 1'b0;
    waddr    = ptr_q[AW-1:0];
    wdata    = {ver_q, te_q, ts_q};
    raddr    = ptr_q[AW-1:0];
    sub_a    = now_q;
    sub_b    = rd_end;
    win_load = 1'b0;
    pre_load = 1'b0;
    fin      = 1'b0;
    status_d = 1'b0;
    cur_d    = ST_INACTIVE;
    nt_d     = '0;
    ns_d     = ST_INACTIVE;
    nv_d     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (action_e'(action_i))
            ACT_CLEAR: begin
              count_d = '0;
              fin     = 1'b1;
            end
            ACT_INSERT: begin
              if (count_q == CW'(MAX_WINDOWS)) begin
                status_d = 1'b1;
                fin      = 1'b1;
              end else begin
                ptr_d = count_q;
                if (count_q == '0) begin
                  state_d = S_INS_WR;
                end else begin
                  raddr   = cnt_m1[AW-1:0];
                  state_d = S_INS_CMP;
                end
              end
            end
            ACT_QUERY: begin
              ptr_d = '0;
              if (count_q == '0) begin
                fin = 1'b1;
              end else begin
                raddr   = '0;
                state_d = S_Q_CMP;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_INS_CMP: begin
        sub_a = ts_q;
        sub_b = rd_start;
        if (sub_borrow) begin
          we    = 1'b1;
          wdata = rdata;
          ptr_d = ptr_m1;
          if (ptr_m1 != '0) begin
            raddr = ptr_m2[AW-1:0];
          end else begin
            state_d = S_INS_WR;
          end
        end else begin
          state_d = S_INS_WR;
        end
      end
      S_INS_WR: begin
        we      = 1'b1;
        count_d = count_q + CW'(1);
        if (ptr_q == '0) begin
          rs_d = ts_q;
        end
        if (ptr_q == count_q) begin
          re_d = te_q;
        end
        fin     = 1'b1;
        state_d = S_IDLE;
      end
      S_Q_CMP: begin
        if (sub_borrow) begin
          win_load = 1'b1;
          state_d  = S_Q_ACT;
        end else begin
          ptr_d = ptr_p1;
          if (ptr_p1 == count_q) begin
            fin     = 1'b1;
            state_d = S_IDLE;
          end else begin
            raddr = ptr_p1[AW-1:0];
          end
        end
      end
      S_Q_ACT: begin
        sub_b = win_s_q;
        if (!sub_borrow) begin
          fin     = 1'b1;
          cur_d   = ST_ACTIVE;
          nt_d    = win_e_q;
          ns_d    = ST_INACTIVE;
          nv_d    = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_Q_LEAD;
        end
      end
      S_Q_LEAD: begin
        sub_a    = win_s_q;
        sub_b    = TIME_BITS'(lead_q);
        pre_load = 1'b1;
        state_d  = S_Q_PRE;
      end
      S_Q_PRE: begin
        sub_b   = pre_q;
        fin     = 1'b1;
        nv_d    = 1'b1;
        state_d = S_IDLE;
        if (!sub_borrow) begin
          cur_d = ST_ESTABLISHED;
          nt_d  = win_s_q;
          ns_d  = ST_ACTIVE;
        end else begin
          cur_d = ST_INACTIVE;
          nt_d  = pre_q;
          ns_d  = ST_ESTABLISHED;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    orv_d = (count_d != '0);
    ors_d = orv_d ? rs_d : '0;
    ore_d = orv_d ? re_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      lead_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= fin;
      if (lead_we_i) begin
        lead_q <= lead_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    rs_q  <= rs_d;
    re_q  <= re_d;
    if (state_q == S_IDLE && start) begin
      ts_q  <= start_time_i;
      te_q  <= end_time_i;
      ver_q <= version_i;
      now_q <= now_time_i;
    end
    if (win_load) begin
      win_s_q <= rd_start;
      win_e_q <= rd_end;
    end
    if (pre_load) begin
      pre_q <= sub_borrow ? '0 : sub_diff;
    end
    if (fin) begin
      status_q <= status_d;
      cur_q    <= cur_d;
      nt_q     <= nt_d;
      ns_q     <= ns_d;
      nv_q     <= nv_d;
      ors_q    <= ors_d;
      ore_q    <= ore_d;
      orv_q    <= orv_d;
      ocnt_q   <= count_d;
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign current_state_o = cur_q;
  assign next_time_o     = nt_q;
  assign next_state_o    = ns_q;
  assign next_valid_o    = nv_q;
  assign range_start_o   = ors_q;
  assign range_end_o     = ore_q;
  assign range_valid_o   = orv_q;
  assign window_count_o  = ocnt_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_WINDOWS))
    else $error("window count beyond table depth");

  a_onehot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result strobed while sequencer busy");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q) |-> (window_count_o == CW'(MAX_WINDOWS)))
    else $error("insert dropped while table not full");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_q))
    else $error("accepted word neither in progress nor finished");
`endif

endmodule

>>> tb/tb_time_window_schedule_state.sv
// ----------------------------------------------------------------------------
// Time window schedule state testbench
// Drives clear, insert and query commands into the schedule table, keeps its
// own sorted copy of the table and the lead register, and compares every
// strobed result word field by field against the word predicted for it.
// ----------------------------------------------------------------------------
module tb_time_window_schedule_state;
  import tws_pkg::*;

  localparam int TB      = TIME_BITS_DEF;
  localparam int MAXW    = MAX_WINDOWS_DEF;
  localparam int LIMIT   = 400000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef logic [TB-1:0] tstamp_t;

  typedef struct packed {
    logic       status;
    win_state_e cur_state;
    tstamp_t    next_time;
    win_state_e next_state;
    logic       next_valid;
    tstamp_t    range_start;
    tstamp_t    range_end;
    logic       range_valid;
    logic [4:0] win_count;
  } sched_word_t;

  logic                   clk_i        = 1'b0;
  logic                   rst_ni       = 1'b0;
  logic                   start        = 1'b0;
  logic                   busy;
  logic [1:0]             action_i     = ACT_CLEAR;
  tstamp_t                start_time_i = '0;
  tstamp_t                end_time_i   = '0;
  logic [VER_W-1:0]       version_i    = '0;
  tstamp_t                now_time_i   = '0;
  logic                   lead_we_i    = 1'b0;
  logic [LEAD_W-1:0]      lead_wdata_i = '0;
  logic                   done_o;
  logic                   status_o;
  logic [1:0]             current_state_o;
  tstamp_t                next_time_o;
  logic [1:0]             next_state_o;
  logic                   next_valid_o;
  tstamp_t                range_start_o;
  tstamp_t                range_end_o;
  logic                   range_valid_o;
  logic [4:0]             window_count_o;

  tstamp_t          tbl_start [MAXW];
  tstamp_t          tbl_end [MAXW];
  logic [VER_W-1:0] tbl_ver [MAXW];
  int               tbl_count = 0;
  logic [LEAD_W-1:0] lead_cfg = '0;

  sched_word_t expected_words[$];
  sched_word_t due_word;
  int          err_count  = 0;
  int          cycle_count = 0;
  int          gap_pct    = 0;
  int          lead_pick  = 0;

  time_window_schedule_state u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .start_time_i   (start_time_i),
    .end_time_i     (end_time_i),
    .version_i      (version_i),
    .now_time_i     (now_time_i),
    .lead_we_i      (lead_we_i),
    .lead_wdata_i   (lead_wdata_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .current_state_o(current_state_o),
    .next_time_o    (next_time_o),
    .next_state_o   (next_state_o),
    .next_valid_o   (next_valid_o),
    .range_start_o  (range_start_o),
    .range_end_o    (range_end_o),
    .range_valid_o  (range_valid_o),
    .window_count_o (window_count_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // The establish point is the window start less the lead, held at zero.
  function automatic tstamp_t lead_edge(tstamp_t s);
    return (s > tstamp_t'(lead_cfg)) ? s - tstamp_t'(lead_cfg) : '0;
  endfunction

  function automatic sched_word_t apply_action(logic [1:0] act, tstamp_t s, tstamp_t e,
                                               logic [VER_W-1:0] v, tstamp_t now);
    sched_word_t w;
    int          pos;
    int          i;
    bit          found;
    tstamp_t     pre;
    w = '0;
    found = 0;
    case (act)
      ACT_CLEAR: begin
        tbl_count = 0;
      end
      ACT_INSERT: begin
        if (tbl_count >= MAXW) begin
          w.status = 1'b1;
        end else begin
          pos = tbl_count;
          while (pos > 0 && tbl_start[pos-1] > s) pos--;
          for (i = tbl_count; i > pos; i--) begin
            tbl_start[i] = tbl_start[i-1];
            tbl_end[i]   = tbl_end[i-1];
            tbl_ver[i]   = tbl_ver[i-1];
          end
          tbl_start[pos] = s;
          tbl_end[pos]   = e;
          tbl_ver[pos]   = v;
          tbl_count++;
        end
      end
      ACT_QUERY: begin
        for (i = 0; i < tbl_count; i++) begin
          if (!found && tbl_end[i] > now) begin
            found = 1;
            w.next_valid = 1'b1;
            if (tbl_start[i] <= now) begin
              w.cur_state  = ST_ACTIVE;
              w.next_time  = tbl_end[i];
              w.next_state = ST_INACTIVE;
            end else begin
              pre = lead_edge(tbl_start[i]);
              if (pre <= now) begin
                w.cur_state  = ST_ESTABLISHED;
                w.next_time  = tbl_start[i];
                w.next_state = ST_ACTIVE;
              end else begin
                w.cur_state  = ST_INACTIVE;
                w.next_time  = pre;
                w.next_state = ST_ESTABLISHED;
              end
            end
          end
        end
      end
      default: ;
    endcase
    if (tbl_count > 0) begin
      w.range_start = tbl_start[0];
      w.range_end   = tbl_end[tbl_count-1];
      w.range_valid = 1'b1;
    end
    w.win_count = tbl_count[4:0];
    return w;
  endfunction

  task automatic report_mismatch(string msg);
    if (err_count < 200) $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result word with nothing outstanding");
      end else begin
        due_word = expected_words.pop_front();
        check_field("status", 64'(status_o), 64'(due_word.status));
        check_field("current_state", 64'(current_state_o), 64'(due_word.cur_state));
        check_field("next_time", 64'(next_time_o), 64'(due_word.next_time));
        check_field("next_state", 64'(next_state_o), 64'(due_word.next_state));
        check_field("next_valid", 64'(next_valid_o), 64'(due_word.next_valid));
        check_field("range_start", 64'(range_start_o), 64'(due_word.range_start));
        check_field("range_end", 64'(range_end_o), 64'(due_word.range_end));
        check_field("range_valid", 64'(range_valid_o), 64'(due_word.range_valid));
        check_field("window_count", 64'(window_count_o), 64'(due_word.win_count));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("time_window_schedule_state verification failed");
      $finish;
    end
  end

  // Leaves start high on return, so the caller must drive it in the same step.
  task automatic send_word(logic [1:0] act, tstamp_t s, tstamp_t e,
                           logic [VER_W-1:0] v, tstamp_t now);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    action_i     <= act;
    start_time_i <= s;
    end_time_i   <= e;
    version_i    <= v;
    now_time_i   <= now;
    do @(posedge clk_i); while (busy);
    expected_words = {expected_words, apply_action(act, s, e, v, now)};
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_lead(logic [LEAD_W-1:0] val);
    drain_results();
    lead_we_i    <= 1'b1;
    lead_wdata_i <= val;
    @(posedge clk_i);
    lead_cfg = val;
    lead_we_i <= 1'b0;
  endtask

  function automatic tstamp_t rand_near(tstamp_t base);
    if ($urandom_range(0, 15) == 0) return tstamp_t'({$urandom, $urandom});
    return base + tstamp_t'($urandom_range(0, 120));
  endfunction

  // Queries mostly land on the edges of a stored window.
  function automatic tstamp_t pick_now(tstamp_t base);
    int      i;
    tstamp_t s;
    tstamp_t e;
    if (tbl_count == 0 || $urandom_range(0, 3) == 0) return rand_near(base);
    i = $urandom_range(0, tbl_count - 1);
    s = tbl_start[i];
    e = tbl_end[i];
    case ($urandom_range(0, 6))
      0: return s;
      1: return s - 1;
      2: return e;
      3: return e - 1;
      4: return lead_edge(s);
      5: return lead_edge(s) - 1;
      default: return s + 1;
    endcase
  endfunction

  task automatic random_word(tstamp_t base);
    int          r;
    logic [1:0]  act;
    tstamp_t     s;
    tstamp_t     e;
    r = $urandom_range(0, 99);
    if (r < 3) act = ACT_CLEAR;
    else if (r < 5) act = ACT_UNUSED;
    else if (r < 50) act = ACT_INSERT;
    else act = ACT_QUERY;
    s = rand_near(base);
    case ($urandom_range(0, 9))
      0: e = tstamp_t'({$urandom, $urandom});
      1: e = s - tstamp_t'($urandom_range(0, 4));
      default: e = s + tstamp_t'($urandom_range(1, 40));
    endcase
    send_word(act, s, e, $urandom, pick_now(base));
  endtask

  task automatic test_empty_table();
    gap_pct = 0;
    send_word(ACT_QUERY, '0, '0, '0, '0);
    send_word(ACT_UNUSED, '1, '1, '1, '1);
    send_word(ACT_QUERY, '1, '1, '1, '1);
  endtask

  task automatic test_insert_order_and_overflow();
    int k;
    send_word(ACT_INSERT, 48'd100, 48'd200, 32'd1, '0);
    send_word(ACT_INSERT, 48'd50, 48'd60, 32'd2, '0);
    send_word(ACT_INSERT, 48'd100, 48'd150, 32'd3, '0);
    send_word(ACT_INSERT, 48'd0, 48'd10, 32'd4, '0);
    send_word(ACT_INSERT, '1, '1, '1, '1);
    send_word(ACT_INSERT, 48'd300, 48'd250, 32'd5, '0);
    for (k = 0; k < 10; k++) begin
      send_word(ACT_INSERT, tstamp_t'(400 + 10 * k), tstamp_t'(405 + 10 * k), k, '0);
    end
    send_word(ACT_INSERT, '1, '1, '1, '0);
  endtask

  task automatic test_establish_lead();
    write_lead(32'd20);
    send_word(ACT_QUERY, '0, '0, '0, 48'd0);
    send_word(ACT_QUERY, '0, '0, '0, 48'd10);
    send_word(ACT_QUERY, '0, '0, '0, 48'd30);
    send_word(ACT_QUERY, '0, '0, '0, 48'd50);
    write_lead('1);
    send_word(ACT_QUERY, '0, '0, '0, 48'd12);
    send_word(ACT_QUERY, '0, '0, '0, '1 - 1);
    send_word(ACT_QUERY, '0, '0, '0, '1);
    send_word(ACT_CLEAR, '1, '1, '1, '1);
  endtask

  task automatic test_random_traffic(int idle_pct, int chunks);
    int      c;
    tstamp_t base;
    for (c = 0; c < chunks; c++) begin
      case (lead_pick % 4)
        0: write_lead('0);
        1: write_lead('1);
        2: write_lead($urandom_range(1, 64));
        default: write_lead($urandom);
      endcase
      lead_pick++;
      gap_pct = idle_pct;
      case ($urandom_range(0, 3))
        0: base = '0;
        1: base = '1 - 255;
        2: base = 48'h0000_FFFF_FF80;
        default: base = tstamp_t'({$urandom, $urandom});
      endcase
      repeat (100) random_word(base);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_table();
    test_insert_order_and_overflow();
    test_establish_lead();
    test_random_traffic(22, 4);
    test_random_traffic(48, 4);
    test_random_traffic(0, 5);
    drain_results();
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("time_window_schedule_state verification clean");
    end else begin
      $display("time_window_schedule_state verification failed");
    end
    $finish;
  end

endmodule
